FILE: design/caf_pkg.sv
// shared types, constants and elaboration-time helpers for the attitude filter
// no dependencies; imported by every module of the block
`default_nettype none
package caf_pkg;

    // internal cordic datapath width and angle width (q29 radians)
    localparam int CW = 60;
    localparam int ZW = 34;

    localparam logic signed [ZW-1:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [ZW-1:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [CW-1:0] GAIN_Q30    = 60'sd652032874;
    localparam logic signed [18:0]   DEG90_Q13   = 19'sd12868;
    localparam logic [15:0]          WEIGHT_ONE  = 16'h8000;

    // configuration register indexes
    localparam logic [2:0] CFG_BLEND_ROLL    = 3'd0;
    localparam logic [2:0] CFG_BLEND_PITCH   = 3'd1;
    localparam logic [2:0] CFG_BLEND_YAW     = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd3;
    localparam logic [2:0] CFG_RESTRICT_MODE = 3'd4;

    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
    } caf_in_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               yaw_jump;
    } caf_out_t;

    typedef enum logic [1:0] {CS_IDLE, CS_NORM, CS_ITER, CS_DONE} cordic_state_t;
    typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_DONE} sqrt_state_t;
    typedef enum logic [1:0] {U_NONE, U_MUL, U_SQRT, U_CORDIC} unit_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQRT, ST_ATAN_R, ST_ATAN_P, ST_SC_R, ST_SC_P,
        ST_XH0, ST_XH1, ST_XH2, ST_XH3, ST_XH4, ST_YH0, ST_YH1, ST_ATAN_H,
        ST_GYRO_R, ST_GYRO_P, ST_GYRO_Y, ST_BL_R0, ST_BL_R1, ST_BL_P0, ST_BL_P1,
        ST_BL_Y0, ST_BL_Y1, ST_FIN
    } filt_state_t;

    typedef struct packed {
        logic start;
        logic rotate;
    } cordic_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [ZW-1:0]  angle;
        logic signed [17:0]    sin_q15;
        logic signed [17:0]    cos_q15;
    } cordic_rsp_t;

    // shift-subtract division, used only while building the arctangent table
    function automatic longint unsigned cdiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in q29 from the odd power series, rounded to nearest
    function automatic longint atan_q29(input int i);
        longint          acc;
        longint unsigned t;
        int              k;
        acc = 0;
        k = 0;
        if (i == 0) return 64'sd421657428;
        while (i * (2 * k + 1) <= 60) begin
            t = cdiv(64'd1 << (60 - i * (2 * k + 1)), longint'(2 * k + 1));
            if ((k & 1) != 0) acc = acc - longint'(t);
            else acc = acc + longint'(t);
            k++;
        end
        return (acc + (64'sd1 <<< 30)) >>> 31;
    endfunction

endpackage
`default_nettype wire

FILE: design/caf_mul.sv
// shared signed multiplier with a registered product
// depends on caf_pkg
`default_nettype none
module caf_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] op_a,
    input  wire logic signed [24:0] op_b,
    output logic                    done,
    output logic signed [56:0]      prod
);
    import caf_pkg::*;

    logic               done_reg;
    logic signed [56:0] prod_reg;
    logic signed [56:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
        if (start) begin
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: design/caf_isqrt.sv
// iterative floor square root of a 64 bit radicand, one result bit per cycle
// depends on caf_pkg
`default_nettype none
module caf_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    import caf_pkg::*;

    sqrt_state_t state_reg, state_next;
    logic [63:0] n_reg, r_reg, b_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] trial;
    logic        fits;

    assign trial = r_reg + b_reg;
    assign fits  = n_reg >= trial;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE: if (start) state_next = SQ_RUN;
            SQ_RUN:  if (cnt_reg == 5'd31) state_next = SQ_DONE;
            SQ_DONE: state_next = SQ_IDLE;
            default: state_next = SQ_IDLE;
        endcase
    end

    always_comb begin
        done = (state_reg == SQ_DONE);
        root = r_reg[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == SQ_IDLE && start) begin
            n_reg   <= radicand;
            r_reg   <= '0;
            b_reg   <= 64'd1 << 62;
            cnt_reg <= '0;
        end else if (state_reg == SQ_RUN) begin
            if (fits) begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg   <= b_reg >> 2;
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

endmodule
`default_nettype wire

FILE: design/caf_cordic.sv
// iterative cordic: vectoring for atan2 and rotation for sin and cos
// depends on caf_pkg; one micro-rotation per cycle, shared by all angle work
`default_nettype none
module caf_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire caf_pkg::cordic_req_t         req,
    input  wire logic signed [caf_pkg::CW-1:0] x_in,
    input  wire logic signed [caf_pkg::CW-1:0] y_in,
    input  wire logic signed [caf_pkg::ZW-1:0] a_in,
    output caf_pkg::cordic_rsp_t              rsp
);
    import caf_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    cordic_state_t        state_reg, state_next;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IW-1:0]        i_reg;
    logic                 rot_reg, neg_reg;

    logic signed [ZW-1:0] atan_tab [CORDIC_STEPS];
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
        assign atan_tab[g] = ZW'(atan_q29(g));
    end

    logic signed [CW-1:0] x_abs, y_abs, m_val, xs, ys, yv, xv, s_sum, c_sum;
    logic                 m_ready, m_small, last, sel, zero_vec;

    assign x_abs    = x_reg[CW-1] ? -x_reg : x_reg;
    assign y_abs    = y_reg[CW-1] ? -y_reg : y_reg;
    assign m_val    = (x_abs > y_abs) ? x_abs : y_abs;
    assign m_ready  = |m_val[CW-1:55];
    assign m_small  = ~|m_val[54:47];
    assign xs       = x_reg >>> i_reg;
    assign ys       = y_reg >>> i_reg;
    assign last     = (i_reg == IW'(CORDIC_STEPS - 1));
    assign zero_vec = (x_in == '0) && (y_in == '0);
    // add ys to x when vectoring with y >= 0 or rotating with a negative residual
    assign sel      = rot_reg ? z_reg[ZW-1] : ~y_reg[CW-1];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (req.start) begin
                    if (req.rotate) state_next = CS_ITER;
                    else if (zero_vec) state_next = CS_DONE;
                    else state_next = CS_NORM;
                end
            end
            CS_NORM: if (m_ready) state_next = CS_ITER;
            CS_ITER: if (last) state_next = CS_DONE;
            CS_DONE: state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        yv = neg_reg ? -y_reg : y_reg;
        xv = neg_reg ? -x_reg : x_reg;
        s_sum = yv + (CW'(1) <<< 14);
        c_sum = xv + (CW'(1) <<< 14);
        rsp.done    = (state_reg == CS_DONE);
        rsp.angle   = z_reg;
        rsp.sin_q15 = s_sum[32:15];
        rsp.cos_q15 = c_sum[32:15];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        unique case (state_reg)
            CS_IDLE: begin
                if (req.start) begin
                    rot_reg <= req.rotate;
                    i_reg   <= '0;
                    if (req.rotate) begin
                        x_reg <= GAIN_Q30;
                        y_reg <= '0;
                        // fold the angle into the right half plane
                        if (a_in > HALF_PI_Q29) begin
                            z_reg   <= a_in - PI_Q29;
                            neg_reg <= 1'b1;
                        end else if (a_in < -HALF_PI_Q29) begin
                            z_reg   <= a_in + PI_Q29;
                            neg_reg <= 1'b1;
                        end else begin
                            z_reg   <= a_in;
                            neg_reg <= 1'b0;
                        end
                    end else begin
                        neg_reg <= 1'b0;
                        if (x_in[CW-1]) begin
                            x_reg <= -x_in;
                            y_reg <= -y_in;
                            z_reg <= y_in[CW-1] ? -PI_Q29 : PI_Q29;
                        end else begin
                            x_reg <= x_in;
                            y_reg <= y_in;
                            z_reg <= '0;
                        end
                    end
                end
            end
            CS_NORM: begin
                if (!m_ready) begin
                    if (m_small) begin
                        x_reg <= x_reg <<< 8;
                        y_reg <= y_reg <<< 8;
                    end else begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end
                end
            end
            CS_ITER: begin
                if (sel) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_tab[i_reg];
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_tab[i_reg];
                end
                i_reg <= i_reg + IW'(1);
            end
            CS_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/complementary_attitude_filter.sv
// top level of the complementary attitude filter with tilt-compensated heading
// depends on caf_pkg, caf_mul, caf_isqrt and caf_cordic
//
// usage:
//   s_valid/s_ready/s_data carry one gyro, accelerometer and magnetometer sample.
//   m_valid/m_ready/m_data carry the filtered roll, pitch, yaw and the yaw_jump flag;
//   every input transfer gives exactly one result transfer, in order.
//   cfg_wr_en/cfg_index/cfg_wdata write the blend weights, sample period and pitch
//   restriction mode; write only while no sample is in flight.
// timing:
//   the time one sample takes grows with CORDIC_STEPS and with the operand
//   normalization shifts of each arctangent. An arctangent of a zero vector skips
//   its normalization and its micro-rotations. The five passes through the single
//   cordic unit, the square root step and the 18 products on the one multiplier
//   run strictly one after another, so a new sample is taken only once the
//   previous one has finished.
//   s_ready is high whenever the sequencer is idle, also while a result waits.
// reset:
//   aresetn (synchronous, active low) clears the kept angles to zero and loads
//   the register defaults. A stalled receiver holds the result in the output
//   register; the next sample may enter but its result waits for that transfer.
`default_nettype none
module complementary_attitude_filter #(
    parameter int CORDIC_STEPS = 16,
    parameter int SENSOR_WIDTH = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire caf_pkg::caf_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output caf_pkg::caf_out_t      m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [23:0]       cfg_wdata
);
    import caf_pkg::*;

    localparam int SH = 24 - SENSOR_WIDTH;
    localparam int PW = 21;
    localparam int BW = 40;

    function automatic logic signed [24:0] sens(input logic [15:0] f);
        logic [23:0]        z;
        logic signed [23:0] t;
        z = {8'b0, f} << SH;
        t = $signed(z) >>> SH;
        return {t[23], t};
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [24:0] v);
        if (v > 25'sd32767) return 16'sh7fff;
        if (v < -25'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] sat_w(input logic [15:0] w);
        return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    endfunction

    // configuration
    logic [15:0] w_roll_reg, w_pitch_reg, w_yaw_reg;
    logic [23:0] period_reg;
    logic        mode_reg;

    // sequencer and datapath
    filt_state_t          state_reg, state_next;
    logic                 issued_reg;
    caf_in_t              in_reg;
    logic [47:0]          sq_reg;
    logic [31:0]          nrm_reg;
    logic signed [ZW-1:0] r29_reg, p29_reg, h29_reg;
    logic signed [17:0]   sr_reg, cr_reg, sp_reg, cp_reg;
    logic signed [31:0]   t_reg;
    logic signed [CW-1:0] xh_reg, yh_reg;
    logic signed [PW-1:0] prop_r_reg, prop_p_reg, prop_y_reg;
    logic signed [BW-1:0] bacc_reg;
    logic signed [15:0]   roll_reg, pitch_reg, yaw_reg;
    logic signed [15:0]   nr_reg, np_reg, ny_reg;
    logic                 m_valid_reg;
    caf_out_t             m_data_reg;

    // unit hookups
    unit_sel_t            unit;
    logic                 mul_start, mul_done, sq_start, sq_done, step_done;
    logic signed [31:0]   mul_a;
    logic signed [24:0]   mul_b;
    logic signed [56:0]   prod;
    logic [31:0]          root;
    cordic_req_t          cor_req;
    cordic_rsp_t          cor_rsp;
    logic                 cor_rotate;
    logic signed [CW-1:0] cor_x, cor_y;
    logic signed [ZW-1:0] cor_a;

    logic signed [24:0]   ax, ay, az, mx, my, mz, na, dt_b;
    logic [15:0]          wt_r, wt_p, wt_y;
    logic signed [56:0]   inc_sum;
    logic signed [19:0]   gyro_inc;
    logic signed [ZW-1:0] rm_sum, pm_sum, hm_sum;
    logic signed [17:0]   rm, pm, hm;
    logic signed [BW-1:0] bl_sum;
    logic signed [24:0]   bl_q;
    logic signed [18:0]   yaw_diff, yaw_mag;
    logic                 jump;
    logic signed [24:0]   jump_ny;
    logic                 out_free;

    assign ax   = sens(in_reg.accel_x);
    assign ay   = sens(in_reg.accel_y);
    assign az   = sens(in_reg.accel_z);
    assign mx   = sens(in_reg.mag_x);
    assign my   = sens(in_reg.mag_y);
    assign mz   = sens(in_reg.mag_z);
    assign na   = mode_reg ? ay : ax;
    assign dt_b = $signed({1'b0, period_reg});
    assign wt_r = sat_w(w_roll_reg);
    assign wt_p = sat_w(w_pitch_reg);
    assign wt_y = sat_w(w_yaw_reg);

    assign inc_sum  = prod + (57'sd1 <<< 20);
    assign gyro_inc = inc_sum[40:21];
    assign rm_sum   = r29_reg + (ZW'(1) <<< 15);
    assign pm_sum   = p29_reg + (ZW'(1) <<< 15);
    assign hm_sum   = h29_reg + (ZW'(1) <<< 15);
    assign rm       = rm_sum[ZW-1:16];
    assign pm       = pm_sum[ZW-1:16];
    assign hm       = hm_sum[ZW-1:16];
    assign bl_sum   = bacc_reg + BW'(prod) + BW'(16384);
    assign bl_q     = bl_sum[39:15];
    assign yaw_diff = 19'(hm) - 19'(yaw_reg);
    assign yaw_mag  = yaw_diff[18] ? -yaw_diff : yaw_diff;
    assign jump     = yaw_mag > DEG90_Q13;
    // heading minus the yaw increment, with the increment recovered from prop_y
    assign jump_ny  = 25'(hm) + 25'(yaw_reg) - 25'(prop_y_reg);
    assign out_free = !m_valid_reg || m_ready;

    caf_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .prod(prod)
    );

    caf_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .radicand({sq_reg, 16'b0}), .done(sq_done), .root(root)
    );

    caf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(cor_req),
        .x_in(cor_x), .y_in(cor_y), .a_in(cor_a), .rsp(cor_rsp)
    );

    // next state: a fixed program, each step waits for its unit
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SQ_A;
            ST_SQ_A:   if (step_done) state_next = ST_SQ_B;
            ST_SQ_B:   if (step_done) state_next = ST_SQRT;
            ST_SQRT:   if (step_done) state_next = ST_ATAN_R;
            ST_ATAN_R: if (step_done) state_next = ST_ATAN_P;
            ST_ATAN_P: if (step_done) state_next = ST_SC_R;
            ST_SC_R:   if (step_done) state_next = ST_SC_P;
            ST_SC_P:   if (step_done) state_next = ST_XH0;
            ST_XH0:    if (step_done) state_next = ST_XH1;
            ST_XH1:    if (step_done) state_next = ST_XH2;
            ST_XH2:    if (step_done) state_next = ST_XH3;
            ST_XH3:    if (step_done) state_next = ST_XH4;
            ST_XH4:    if (step_done) state_next = ST_YH0;
            ST_YH0:    if (step_done) state_next = ST_YH1;
            ST_YH1:    if (step_done) state_next = ST_ATAN_H;
            ST_ATAN_H: if (step_done) state_next = ST_GYRO_R;
            ST_GYRO_R: if (step_done) state_next = ST_GYRO_P;
            ST_GYRO_P: if (step_done) state_next = ST_GYRO_Y;
            ST_GYRO_Y: if (step_done) state_next = ST_BL_R0;
            ST_BL_R0:  if (step_done) state_next = ST_BL_R1;
            ST_BL_R1:  if (step_done) state_next = ST_BL_P0;
            ST_BL_P0:  if (step_done) state_next = ST_BL_P1;
            ST_BL_P1:  if (step_done) state_next = ST_BL_Y0;
            ST_BL_Y0:  if (step_done) state_next = ST_BL_Y1;
            ST_BL_Y1:  if (step_done) state_next = ST_FIN;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // per-step unit selection and operands
    always_comb begin
        unit       = U_NONE;
        mul_a      = '0;
        mul_b      = '0;
        cor_rotate = 1'b0;
        cor_x      = '0;
        cor_y      = '0;
        cor_a      = '0;
        unique case (state_reg)
            ST_SQ_A:   begin unit = U_MUL; mul_a = 32'(na); mul_b = na; end
            ST_SQ_B:   begin unit = U_MUL; mul_a = 32'(az); mul_b = az; end
            ST_SQRT:   unit = U_SQRT;
            ST_ATAN_R: begin
                unit = U_CORDIC;
                if (mode_reg) begin
                    cor_y = CW'(ay);
                    cor_x = CW'(az);
                end else begin
                    cor_y = CW'(ay) <<< 8;
                    cor_x = $signed({28'b0, nrm_reg});
                end
            end
            ST_ATAN_P: begin
                unit = U_CORDIC;
                if (mode_reg) begin
                    cor_y = -(CW'(ax) <<< 8);
                    cor_x = $signed({28'b0, nrm_reg});
                end else begin
                    cor_y = -CW'(ax);
                    cor_x = CW'(az);
                end
            end
            ST_SC_R:   begin unit = U_CORDIC; cor_rotate = 1'b1; cor_a = r29_reg; end
            ST_SC_P:   begin unit = U_CORDIC; cor_rotate = 1'b1; cor_a = p29_reg; end
            ST_XH0:    begin unit = U_MUL; mul_a = 32'(cp_reg); mul_b = mx; end
            ST_XH1:    begin unit = U_MUL; mul_a = 32'(sr_reg); mul_b = 25'(sp_reg); end
            ST_XH2:    begin unit = U_MUL; mul_a = t_reg; mul_b = my; end
            ST_XH3:    begin unit = U_MUL; mul_a = 32'(sp_reg); mul_b = 25'(cr_reg); end
            ST_XH4:    begin unit = U_MUL; mul_a = t_reg; mul_b = mz; end
            ST_YH0:    begin unit = U_MUL; mul_a = 32'(cr_reg); mul_b = my; end
            ST_YH1:    begin unit = U_MUL; mul_a = 32'(sr_reg); mul_b = mz; end
            ST_ATAN_H: begin unit = U_CORDIC; cor_y = -yh_reg; cor_x = xh_reg; end
            ST_GYRO_R: begin unit = U_MUL; mul_a = 32'(in_reg.gyro_x); mul_b = dt_b; end
            ST_GYRO_P: begin unit = U_MUL; mul_a = 32'(in_reg.gyro_y); mul_b = dt_b; end
            ST_GYRO_Y: begin unit = U_MUL; mul_a = 32'(in_reg.gyro_z); mul_b = dt_b; end
            ST_BL_R0:  begin
                unit = U_MUL; mul_a = 32'(prop_r_reg); mul_b = $signed({9'b0, wt_r});
            end
            ST_BL_R1:  begin
                unit = U_MUL; mul_a = 32'(rm);
                mul_b = $signed({9'b0, WEIGHT_ONE - wt_r});
            end
            ST_BL_P0:  begin
                unit = U_MUL; mul_a = 32'(prop_p_reg); mul_b = $signed({9'b0, wt_p});
            end
            ST_BL_P1:  begin
                unit = U_MUL; mul_a = 32'(pm);
                mul_b = $signed({9'b0, WEIGHT_ONE - wt_p});
            end
            ST_BL_Y0:  begin
                unit = U_MUL; mul_a = 32'(prop_y_reg); mul_b = $signed({9'b0, wt_y});
            end
            ST_BL_Y1:  begin
                unit = U_MUL; mul_a = 32'(hm);
                mul_b = $signed({9'b0, WEIGHT_ONE - wt_y});
            end
            default:   unit = U_NONE;
        endcase
    end

    assign mul_start      = (unit == U_MUL) && !issued_reg;
    assign sq_start       = (unit == U_SQRT) && !issued_reg;
    assign cor_req.start  = (unit == U_CORDIC) && !issued_reg;
    assign cor_req.rotate = cor_rotate;
    assign step_done = ((unit == U_MUL) && mul_done) || ((unit == U_SQRT) && sq_done) ||
                       ((unit == U_CORDIC) && cor_rsp.done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            w_roll_reg  <= 16'd32113;
            w_pitch_reg <= 16'd32113;
            w_yaw_reg   <= 16'd32113;
            period_reg  <= 24'd167772;
            mode_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (step_done) issued_reg <= 1'b0;
            else if (mul_start || sq_start || cor_req.start) issued_reg <= 1'b1;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_BLEND_ROLL:    w_roll_reg  <= cfg_wdata[15:0];
                    CFG_BLEND_PITCH:   w_pitch_reg <= cfg_wdata[15:0];
                    CFG_BLEND_YAW:     w_yaw_reg   <= cfg_wdata[15:0];
                    CFG_SAMPLE_PERIOD: period_reg  <= cfg_wdata;
                    CFG_RESTRICT_MODE: mode_reg    <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
                roll_reg    <= nr_reg;
                pitch_reg   <= np_reg;
                yaw_reg     <= jump ? clamp16(jump_ny) : ny_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (state_reg == ST_IDLE && s_valid) in_reg <= s_data;
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg.roll     <= nr_reg;
            m_data_reg.pitch    <= np_reg;
            m_data_reg.yaw      <= jump ? clamp16(jump_ny) : ny_reg;
            m_data_reg.yaw_jump <= jump;
        end

        if (step_done) begin
            unique case (state_reg)
                ST_SQ_A:   sq_reg <= prod[47:0];
                ST_SQ_B:   sq_reg <= sq_reg + prod[47:0];
                ST_SQRT:   nrm_reg <= root;
                ST_ATAN_R: r29_reg <= cor_rsp.angle;
                ST_ATAN_P: p29_reg <= cor_rsp.angle;
                ST_SC_R:   begin sr_reg <= cor_rsp.sin_q15; cr_reg <= cor_rsp.cos_q15; end
                ST_SC_P:   begin sp_reg <= cor_rsp.sin_q15; cp_reg <= cor_rsp.cos_q15; end
                ST_XH0:    xh_reg <= CW'(prod) <<< 15;
                ST_XH1:    t_reg <= prod[31:0];
                ST_XH2:    xh_reg <= xh_reg + CW'(prod);
                ST_XH3:    t_reg <= prod[31:0];
                ST_XH4:    xh_reg <= xh_reg + CW'(prod);
                ST_YH0:    yh_reg <= CW'(prod);
                ST_YH1:    yh_reg <= (yh_reg - CW'(prod)) <<< 15;
                ST_ATAN_H: h29_reg <= cor_rsp.angle;
                ST_GYRO_R: prop_r_reg <= PW'(roll_reg) + PW'(gyro_inc);
                ST_GYRO_P: prop_p_reg <= PW'(pitch_reg) + PW'(gyro_inc);
                ST_GYRO_Y: prop_y_reg <= PW'(yaw_reg) + PW'(gyro_inc);
                ST_BL_R0:  bacc_reg <= BW'(prod);
                ST_BL_R1:  nr_reg <= clamp16(bl_q);
                ST_BL_P0:  bacc_reg <= BW'(prod);
                ST_BL_P1:  np_reg <= clamp16(bl_q);
                ST_BL_Y0:  bacc_reg <= BW'(prod);
                ST_BL_Y1:  ny_reg <= clamp16(bl_q);
                default: begin
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // only one shared unit finishes at a time
    a_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_done, sq_done, cor_rsp.done}))
        else $error("two arithmetic units finished together");

    // a unit reports done only for an operation the sequencer issued
    a_done_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_done || sq_done || cor_rsp.done) |-> issued_reg)
        else $error("unit finished without an issued operation");

    // a fresh result appears only after the final step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside the final step");

    // no new sample enters while an operation is outstanding
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !issued_reg)
        else $error("sample accepted with an operation in flight");

endmodule
`default_nettype wire
